/* rtl/core/ecal_pkg.sv */
// Shared types, constants and the month-length table for the calendar converter.
package ecal_pkg;

  localparam int unsigned TW = 32;  // working seconds value
  localparam int unsigned LW = 25;  // longest span: one leap year in seconds

  localparam logic [LW-1:0] LEN_LEAP  = 25'd31622400;
  localparam logic [LW-1:0] LEN_YEAR  = 25'd31536000;
  localparam logic [LW-1:0] LEN_D31   = 25'd2678400;
  localparam logic [LW-1:0] LEN_D30   = 25'd2592000;
  localparam logic [LW-1:0] LEN_D29   = 25'd2505600;
  localparam logic [LW-1:0] LEN_D28   = 25'd2419200;
  localparam logic [LW-1:0] LEN_DAY   = 25'd86400;
  localparam logic [LW-1:0] LEN_HOUR  = 25'd3600;
  localparam logic [LW-1:0] LEN_MIN   = 25'd60;

  localparam logic [10:0] EPOCH_YEAR  = 11'd1970;
  localparam logic [1:0]  EPOCH_MOD4  = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;

  localparam logic [15:0] ZONE_RESET  = 16'd28800;
  localparam logic        REG_ZONE    = 1'b0;

  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  typedef struct packed {
    logic          ge;
    logic [TW-1:0] diff;
  } sub_res_t;

  function automatic logic [LW-1:0] month_len(input logic [3:0] mon, input logic leap);
    logic [LW-1:0] len;
    case (mon)
      MON_FEB: len = leap ? LEN_D29 : LEN_D28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_D30;
      default: len = LEN_D31;
    endcase
    return len;
  endfunction

endpackage

/* rtl/core/epoch_seconds_to_calendar.sv */
// Top level: epoch seconds to local calendar date and time.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  input     | start / busy         | epoch_seconds_i
//  result    | done_o (one cycle)   | year_o month_o day_of_month_o hour_o
//            |                      | minute_o second_o
//  config    | APB psel/penable     | zone offset at byte address 0
//
// busy stays high while a beat is converted: the sequencer removes whole years, months,
// days, hours and minutes one at a time through the shared subtractor, phase by phase,
// then passes a done state. busy stays high until done_o has shown the result; the next
// beat is accepted at the earliest at the end of the following idle cycle.
// Reset is asynchronous and active low; the zone offset returns to 8 hours.
// The receiver cannot stall; the result is valid only while done_o is high.
module epoch_seconds_to_calendar
  import ecal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] epoch_seconds_i,
  output logic        done_o,
  output logic [10:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]   zone;
  logic [TW-1:0] t;
  logic [LW-1:0] len;
  sub_res_t      res;

  ecal_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .zone_o  (zone)
  );

  ecal_sub_unit u_sub (
    .t_i   (t),
    .len_i (len),
    .res_o (res)
  );

  ecal_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .epoch_seconds_i (epoch_seconds_i),
    .zone_i          (zone),
    .busy            (busy),
    .done_o          (done_o),
    .t_o             (t),
    .len_o           (len),
    .res_i           (res),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_of_month_o  (day_of_month_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o)
  );

endmodule

/* rtl/core/ecal_sub_unit.sv */
// Shared compare-and-subtract unit used for every peeling step.
module ecal_sub_unit
  import ecal_pkg::*;
(
  input  logic [TW-1:0] t_i,
  input  logic [LW-1:0] len_i,
  output sub_res_t      res_o
);

  logic [TW:0] wide;

  assign wide       = {1'b0, t_i} - {{(TW-LW+1){1'b0}}, len_i};
  assign res_o.ge   = ~wide[TW];
  assign res_o.diff = wide[TW-1:0];

endmodule

/* rtl/core/ecal_cfg_regs.sv */
// APB register file holding the zone offset.
module ecal_cfg_regs
  import ecal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] zone_o
);

  logic [15:0] zone_q, zone_d;
  logic        hit;

  assign hit    = (paddr[2] == REG_ZONE);
  assign pready = 1'b1;
  assign prdata = hit ? {16'd0, zone_q} : 32'd0;
  assign zone_o = zone_q;

  always_comb begin
    zone_d = zone_q;
    if (psel && penable && pwrite && hit) begin
      zone_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= ZONE_RESET;
    end else begin
      zone_q <= zone_d;
    end
  end

endmodule

/* rtl/core/ecal_seq.sv */
// Sequencer that peels years, months, days, hours and minutes through the shared unit.
module ecal_seq
  import ecal_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [30:0]   epoch_seconds_i,
  input  logic [15:0]   zone_i,
  output logic          busy,
  output logic          done_o,
  output logic [TW-1:0] t_o,
  output logic [LW-1:0] len_o,
  input  sub_res_t      res_i,
  output logic [10:0]   year_o,
  output logic [3:0]    month_o,
  output logic [4:0]    day_of_month_o,
  output logic [4:0]    hour_o,
  output logic [5:0]    minute_o,
  output logic [5:0]    second_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_YEAR  = 3'd1;
  localparam logic [2:0] S_MONTH = 3'd2;
  localparam logic [2:0] S_DAY   = 3'd3;
  localparam logic [2:0] S_HOUR  = 3'd4;
  localparam logic [2:0] S_MIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [TW-1:0] t_q, t_d;
  logic [10:0]   year_q, year_d;
  logic [3:0]    mon_q, mon_d;
  logic [4:0]    day_q, day_d;
  logic [4:0]    hour_q, hour_d;
  logic [5:0]    min_q, min_d;
  logic [1:0]    m4_q, m4_d;
  logic [6:0]    m100_q, m100_d;
  logic [8:0]    m400_q, m400_d;
  logic          leap;

  assign leap = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);

  always_comb begin
    case (state_q)
      S_YEAR:  len_o = leap ? LEN_LEAP : LEN_YEAR;
      S_MONTH: len_o = month_len(mon_q, leap);
      S_DAY:   len_o = LEN_DAY;
      S_HOUR:  len_o = LEN_HOUR;
      default: len_o = LEN_MIN;
    endcase
  end

  assign t_o = t_q;

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    year_d  = year_q;
    mon_d   = mon_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    m4_d    = m4_q;
    m100_d  = m100_q;
    m400_d  = m400_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          t_d     = {1'b0, epoch_seconds_i} + {16'd0, zone_i};
          year_d  = EPOCH_YEAR;
          mon_d   = 4'd1;
          day_d   = 5'd0;
          hour_d  = 5'd0;
          min_d   = 6'd0;
          m4_d    = EPOCH_MOD4;
          m100_d  = EPOCH_MOD100;
          m400_d  = EPOCH_MOD400;
          state_d = S_YEAR;
        end
      end
      S_YEAR: begin
        if (res_i.ge) begin
          t_d    = res_i.diff;
          year_d = year_q + 11'd1;
          m4_d   = m4_q + 2'd1;
          m100_d = (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
          m400_d = (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
        end else begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        if (mon_q == MON_DEC || !res_i.ge) begin
          state_d = S_DAY;
        end else begin
          t_d   = res_i.diff;
          mon_d = mon_q + 4'd1;
        end
      end
      S_DAY: begin
        if (res_i.ge) begin
          t_d   = res_i.diff;
          day_d = day_q + 5'd1;
        end else begin
          state_d = S_HOUR;
        end
      end
      S_HOUR: begin
        if (res_i.ge) begin
          t_d    = res_i.diff;
          hour_d = hour_q + 5'd1;
        end else begin
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        if (res_i.ge) begin
          t_d   = res_i.diff;
          min_d = min_q + 6'd1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    year_q <= year_d;
    mon_q  <= mon_d;
    day_q  <= day_d;
    hour_q <= hour_d;
    min_q  <= min_d;
    m4_q   <= m4_d;
    m100_q <= m100_d;
    m400_q <= m400_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = (state_q == S_DONE);
  assign year_o         = year_q;
  assign month_o        = mon_q;
  assign day_of_month_o = day_q + 5'd1;
  assign hour_o         = hour_q;
  assign minute_o       = min_q;
  assign second_o       = t_q[5:0];

endmodule

/* rtl/core/ecal_checker.sv */
// Port-level checker for the calendar converter, bound to the top level.
module ecal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [3:0]  month_o,
  input logic [4:0]  hour_o,
  input logic        pready
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted beat");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_o >= 4'd1) && (month_o <= 4'd12) && (hour_o <= 5'd23))
    else $error("result field out of range");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind epoch_seconds_to_calendar ecal_checker u_ecal_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .month_o (month_o),
  .hour_o  (hour_o),
  .pready  (pready)
);

/* tb/tb_epoch_seconds_to_calendar.sv */
// Testbench for epoch_seconds_to_calendar: predicts each date, checks every done_o beat.
`timescale 1ns / 1ps

import ecal_pkg::*;

typedef struct {
  logic [10:0] year;
  logic [3:0]  month;
  logic [4:0]  mday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
} cal_date_t;

class calendar_scoreboard;
  logic [15:0] zone;
  cal_date_t   expected_dates[$];
  int unsigned errors;

  function new();
    zone   = ZONE_RESET;
    errors = 0;
  endfunction

  function void set_zone(logic [15:0] z);
    zone = z;
  endfunction

  function int unsigned pending();
    return expected_dates.size();
  endfunction

  function cal_date_t to_calendar(logic [30:0] epoch);
    cal_date_t      d;
    longint unsigned t;
    longint unsigned span;
    int unsigned    yr;
    logic [3:0]     mon;
    int unsigned    dim;
    bit             leap;
    t  = longint'(epoch) + longint'(zone);
    yr = EPOCH_YEAR;
    while (1) begin
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      span = (leap ? 366 : 365) * 86400;
      if (t < span) break;
      t -= span;
      yr++;
    end
    mon = 4'd1;
    while (mon < MON_DEC) begin
      case (mon)
        MON_FEB: dim = leap ? 29 : 28;
        MON_APR, MON_JUN, MON_SEP, MON_NOV: dim = 30;
        default: dim = 31;
      endcase
      if (t < dim * 86400) break;
      t -= dim * 86400;
      mon++;
    end
    d.year   = yr[10:0];
    d.month  = mon;
    d.mday   = 5'(t / 86400 + 1);
    t        = t % 86400;
    d.hour   = 5'(t / 3600);
    t        = t % 3600;
    d.minute = 6'(t / 60);
    d.second = 6'(t % 60);
    return d;
  endfunction

  function void note_epoch(logic [30:0] epoch);
    expected_dates.push_back(to_calendar(epoch));
  endfunction

  function void cmp_field(string name, int unsigned exp, int unsigned got);
    if (exp !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
      errors++;
    end
  endfunction

  function void check_date(cal_date_t got);
    cal_date_t exp;
    if (expected_dates.size() == 0) begin
      $display("%0t: unexpected result beat, got %0d-%0d-%0d %0d:%0d:%0d", $time,
               got.year, got.month, got.mday, got.hour, got.minute, got.second);
      errors++;
      return;
    end
    exp = expected_dates.pop_front();
    cmp_field("year", exp.year, got.year);
    cmp_field("month", exp.month, got.month);
    cmp_field("day_of_month", exp.mday, got.mday);
    cmp_field("hour", exp.hour, got.hour);
    cmp_field("minute", exp.minute, got.minute);
    cmp_field("second", exp.second, got.second);
  endfunction
endclass

module tb_epoch_seconds_to_calendar;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 158;
  localparam logic [2:0]  ZONE_ADDR   = {REG_ZONE, 2'b00};
  localparam logic [2:0]  SPARE_ADDR  = 3'd4;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic [30:0] epoch_seconds_i = '0;
  logic        done_o;
  logic [10:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  calendar_scoreboard sb = new();
  int unsigned send_idle_pct = 32;
  int unsigned cycle_count   = 0;

  epoch_seconds_to_calendar dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .epoch_seconds_i(epoch_seconds_i),
    .done_o         (done_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        sb.check_date('{year_o, month_o, day_of_month_o, hour_o, minute_o, second_o});
      if (start && !busy)
        sb.note_epoch(epoch_seconds_i);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_epoch(input logic [30:0] secs);
    int unsigned gap;
    gap = 0;
    start           <= 1'b1;
    epoch_seconds_i <= secs;
    do @(posedge clk_i); while (busy);
    while (gap < 30 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_zone(input logic [2:0] addr, input logic [15:0] zone);
    logic [31:0] rd;
    apb_xfer(1'b1, addr, {16'($urandom), zone}, rd);
    if (addr[2] == REG_ZONE)
      sb.set_zone(zone);
    apb_xfer(1'b0, ZONE_ADDR, 32'h0, rd);
    if (rd !== {16'h0, sb.zone}) begin
      $display("%0t: zone readback mismatch, expected %0d, got %0d", $time, sb.zone, rd);
      sb.errors++;
    end
  endtask

  // mostly full range, plus local-midnight crossings and both ends of the range
  function automatic logic [30:0] random_epoch();
    longint      v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      v = longint'($urandom & 32'h7FFF_FFFF);
    else if (pick < 80)
      v = longint'($urandom_range(0, 24855)) * 86400 - longint'(sb.zone)
          + longint'($urandom_range(0, 4)) - 2;
    else if (pick < 90)
      v = longint'($urandom_range(0, 5000000));
    else
      v = 64'd2147483647 - longint'($urandom_range(0, 5000000));
    if (v < 0) v = 0;
    if (v > 64'd2147483647) v = 64'd2147483647;
    return v[30:0];
  endfunction

  initial begin
    logic [30:0] edge_cases[17];
    logic [15:0] zone_sel;
    // year, month and leap-day rollovers in local time at the reset offset
    edge_cases = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'h4000_0000, 31'h2AAA_AAAA, 31'h5555_5555,
                   31'd31507199, 31'd31507200, 31'd36604799, 31'd36604800, 31'd68140799,
                   31'd68140800, 31'd68227200, 31'd951753600, 31'd978278399, 31'd978278400,
                   31'd10339199};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 32;
    foreach (edge_cases[i]) send_epoch(edge_cases[i]);
    drain();
    write_zone(ZONE_ADDR, 16'd0);
    send_epoch(31'd0);
    send_epoch(31'd31535999);
    send_epoch(31'd31536000);
    drain();
    write_zone(ZONE_ADDR, 16'hFFFF);
    send_epoch(31'h7FFF_FFFF);
    drain();
    write_zone(SPARE_ADDR, 16'd1234);
    send_epoch(31'd0);
    drain();
    write_zone(ZONE_ADDR, 16'd50400);
    send_epoch(31'h7FFF_FFFF);
    drain();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 32 : (p < 4) ? 88 : 0;
      case (p)
        0:       zone_sel = 16'd0;
        2:       zone_sel = 16'd50400;
        4:       zone_sel = 16'hFFFF;
        default: zone_sel = 16'($urandom_range(0, 50400));
      endcase
      write_zone(ZONE_ADDR, zone_sel);
      repeat (PHASE_ITEMS) send_epoch(random_epoch());
      drain();
    end

    repeat (250) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
